// ----- rtl/sset_pkg.sv -----
// Shared constants, codes and types for the sorted set engine.
`default_nettype none
package sset_pkg;

  localparam int DEPTH = 16;
  localparam int VAL_W = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic                    apply;
    logic                    op;
    logic signed [VAL_W-1:0] operand;
    logic        [CNT_W-1:0] count;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/sset_cell.sv -----
// One slot of the sorted row: holds a value, compares it and shifts with its neighbors.
`default_nettype none
module sset_cell
  import sset_pkg::*;
(
  input  wire logic                    clk,
  input  wire cell_ctl_t               ctl,
  input  wire logic        [IDX_W-1:0] idx,
  input  wire logic                    is_front,
  input  wire logic signed [VAL_W-1:0] left_val,
  input  wire logic                    left_lt,
  input  wire logic                    left_seen,
  input  wire logic signed [VAL_W-1:0] right_val,
  output logic signed [VAL_W-1:0]      val_q,
  output logic signed [VAL_W-1:0]      val_nxt,
  output logic                         lt,
  output logic                         seen
);

  logic signed [VAL_W-1:0] val_r;
  logic                    held;
  logic                    eq;

  assign held = {1'b0, idx} < ctl.count;
  assign eq   = held && (val_r == ctl.operand);
  // The front slot also counts an equal value as "before", so equals land after it.
  assign lt   = held && ((val_r < ctl.operand) || (is_front && eq));
  assign seen = left_seen | eq;

  always_comb begin
    val_nxt = val_r;
    if (ctl.apply) begin
      if (ctl.op == OP_INSERT) begin
        if (!lt) begin
          val_nxt = left_lt ? ctl.operand : left_val;
        end
      end else begin
        if (seen) begin
          val_nxt = right_val;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_q = val_r;

endmodule
`default_nettype wire

// ----- rtl/sorted_set_insert_delete_top.sv -----
// Sorted set engine: input latch, controller, row of compare-and-shift cells, result register.
// The input latch holds an accepted transaction until the result register takes its outcome.
// Throughput: one transaction per cycle while the result side does not stall; each
// operation is a single compare-and-shift step across the whole cell row.
// Reset (synchronous, rst_n low) empties the table and clears both handshakes;
// stored values are not reset and are only ever read below the entry count.
`default_nettype none
module sorted_set_insert_delete_top
  import sset_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_status,
  output logic [3:0]              out_position,
  output logic [4:0]              out_entry_count,
  output logic signed [31:0]      out_smallest
);

  logic                    busy_r, busy_nxt;
  logic                    op_r;
  logic signed [VAL_W-1:0] operand_r;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [1:0]              status_r;
  logic [IDX_W-1:0]        position_r;
  logic [CNT_W-1:0]        ocount_r;
  logic signed [VAL_W-1:0] smallest_r;

  logic                    fire;
  logic                    accept;
  logic                    full;
  logic                    found;
  logic                    ok;
  logic [IDX_W-1:0]        enc_pos;
  logic [1:0]              status_c;
  cell_ctl_t               ctl;

  logic signed [VAL_W-1:0] val_q   [DEPTH];
  logic signed [VAL_W-1:0] val_nxt [DEPTH];
  logic [DEPTH-1:0]        lt_vec;
  logic [DEPTH-1:0]        seen_vec;

  assign fire     = busy_r && (!out_valid_r || !out_stall);
  assign in_stall = busy_r && !fire;
  assign accept   = in_valid && !in_stall;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign found = seen_vec[DEPTH-1];
  assign ok    = (op_r == OP_INSERT) ? !full : found;

  assign ctl.apply   = fire && ok;
  assign ctl.op      = op_r;
  assign ctl.operand = operand_r;
  assign ctl.count   = count_r;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VAL_W-1:0] lv, rv;
      logic                    llt, lseen;
      if (g == 0) begin : g_front
        assign lv    = '0;
        assign llt   = 1'b1;
        assign lseen = 1'b0;
      end else begin : g_mid
        assign lv    = val_q[g-1];
        assign llt   = lt_vec[g-1];
        assign lseen = seen_vec[g-1];
      end
      if (g == DEPTH - 1) begin : g_back
        assign rv = '0;
      end else begin : g_inner
        assign rv = val_q[g+1];
      end
      sset_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .idx       (IDX_W'(g)),
        .is_front  (g == 0),
        .left_val  (lv),
        .left_lt   (llt),
        .left_seen (lseen),
        .right_val (rv),
        .val_q     (val_q[g]),
        .val_nxt   (val_nxt[g]),
        .lt        (lt_vec[g]),
        .seen      (seen_vec[g])
      );
    end
  endgenerate

  // Insert point is the first slot not "before" the value; delete point is the first match.
  always_comb begin
    enc_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (op_r == OP_INSERT) begin
        if (!lt_vec[i] && ((i == 0) || lt_vec[(i == 0) ? 0 : i-1])) begin
          enc_pos = enc_pos | IDX_W'(i);
        end
      end else begin
        if (seen_vec[i] && ((i == 0) || !seen_vec[(i == 0) ? 0 : i-1])) begin
          enc_pos = enc_pos | IDX_W'(i);
        end
      end
    end
  end

  always_comb begin
    if (op_r == OP_INSERT) begin
      status_c = full ? ST_FULL : ST_OK;
    end else begin
      status_c = found ? ST_OK : ST_NOT_FOUND;
    end
    count_nxt = count_r;
    if (ctl.apply) begin
      count_nxt = (op_r == OP_INSERT) ? count_r + CNT_W'(1) : count_r - CNT_W'(1);
    end
    busy_nxt = accept ? 1'b1 : (fire ? 1'b0 : busy_r);
    out_valid_nxt = fire ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_opcode;
      operand_r <= in_value;
    end
    if (fire) begin
      status_r   <= status_c;
      position_r <= ok ? enc_pos : '0;
      ocount_r   <= count_nxt;
      smallest_r <= (count_nxt != '0) ? val_nxt[0] : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_position    = position_r;
  assign out_entry_count = ocount_r;
  assign out_smallest    = smallest_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds table depth");

  a_fail_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (status_r != ST_OK) |-> position_r == '0)
    else $error("refused transaction reports a nonzero position");

  a_full_refused: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_r == OP_INSERT) && full |=> out_valid_r && (status_r == ST_FULL)
      && $stable(count_r))
    else $error("insert into a full table was not refused");

  a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r && (ocount_r == count_r))
    else $error("result count does not match table count");

endmodule
`default_nettype wire

// ----- verif/tb_sorted_set_insert_delete_top.sv -----
// Self-checking testbench for the sorted set insert/delete engine.
`timescale 1ns / 100ps

module tb_sorted_set_insert_delete_top;
  import sset_pkg::*;

  localparam int RESULT_LATENCY = 2;
  localparam int CYCLE_LIMIT    = 400000;

  typedef struct packed {
    logic [1:0]              status;
    logic [IDX_W-1:0]        position;
    logic [CNT_W-1:0]        entry_count;
    logic signed [VAL_W-1:0] smallest;
  } table_result_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_opcode;
  logic signed [VAL_W-1:0] in_value;
  logic                    out_valid;
  logic                    out_stall;
  logic [1:0]              out_status;
  logic [3:0]              out_position;
  logic [4:0]              out_entry_count;
  logic signed [31:0]      out_smallest;

  // Local copy of the sorted table, updated as each transaction is accepted.
  logic signed [VAL_W-1:0] model_vals [DEPTH];
  int                      model_count = 0;

  table_result_t pending_results [$];
  table_result_t want_res;
  int            error_count = 0;
  int            cycle_count = 0;
  int            hold_left   = 0;
  bit            in_gaps_on;
  bit            out_gaps_on;

  sorted_set_insert_delete_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_position    (out_position),
    .out_entry_count (out_entry_count),
    .out_smallest    (out_smallest)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic table_result_t apply_table_op(input logic op,
                                                   input logic signed [VAL_W-1:0] v);
    table_result_t r;
    int            p;
    r.status   = ST_OK;
    r.position = '0;
    if (op == OP_INSERT) begin
      if (model_count >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (model_count == 0 || model_vals[0] > v) begin
          p = 0;
        end else begin
          // A value not below the front entry never goes ahead of it.
          p = 1;
          while (p < model_count && model_vals[p] < v) p++;
        end
        for (int i = model_count; i > p; i--) model_vals[i] = model_vals[i-1];
        model_vals[p] = v;
        model_count++;
        r.position = IDX_W'(p);
      end
    end else begin
      p = 0;
      while (p < model_count && model_vals[p] != v) p++;
      if (p >= model_count) begin
        r.status = ST_NOT_FOUND;
      end else begin
        for (int i = p; i + 1 < model_count; i++) model_vals[i] = model_vals[i+1];
        model_count--;
        r.position = IDX_W'(p);
      end
    end
    r.entry_count = CNT_W'(model_count);
    r.smallest    = (model_count > 0) ? model_vals[0] : '0;
    return r;
  endfunction

  // Mix of small values, held values, extremes and full-range noise so that
  // equal values and sign bits both get plenty of exercise.
  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return VAL_W'($urandom_range(0, 8)) - VAL_W'(4);
      1: begin
        if (model_count > 0) return model_vals[$urandom_range(0, model_count - 1)];
        else return $urandom();
      end
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    error_count++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_txn(input logic op, input logic signed [VAL_W-1:0] v);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_table_op(op, v));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  task automatic test_directed();
    send_txn(OP_DELETE, 32'sd5);
    send_txn(OP_INSERT, 32'sd0);
    send_txn(OP_INSERT, 32'sh7fffffff);
    send_txn(OP_INSERT, 32'sh80000000);
    send_txn(OP_INSERT, 32'sd0);
    // Equal to the front entry: lands right behind it.
    send_txn(OP_INSERT, 32'sh80000000);
    send_txn(OP_DELETE, 32'sd0);
    send_txn(OP_DELETE, 32'sd12345);
    send_txn(OP_DELETE, 32'sh7fffffff);
    for (int k = 0; k < 13; k++) send_txn(OP_INSERT, VAL_W'(k * 7 - 40));
    send_txn(OP_INSERT, -32'sd1);
    send_txn(OP_DELETE, 32'sd777);
    send_txn(OP_DELETE, 32'sh80000000);
    wait_for_results();
  endtask

  // Alternates insert-heavy and delete-heavy stretches so the table keeps
  // swinging between full and nearly empty.
  task automatic test_random_mix(input int n_items);
    logic signed [VAL_W-1:0] v;
    int                      insert_pct;
    insert_pct = 20;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) insert_pct = 100 - insert_pct;
      if ($urandom_range(1, 100) <= insert_pct) begin
        send_txn(OP_INSERT, pick_value());
      end else begin
        if (model_count > 0 && $urandom_range(0, 9) < 7) begin
          v = model_vals[$urandom_range(0, model_count - 1)];
        end else begin
          v = pick_value();
        end
        send_txn(OP_DELETE, v);
      end
    end
    wait_for_results();
  endtask

  task automatic test_result_backpressure();
    hold_left = 80;
    for (int k = 0; k < 24; k++) begin
      send_txn($urandom_range(0, 1) ? OP_DELETE : OP_INSERT, pick_value());
    end
    wait_for_results();
  endtask

  // Result side: long hold-off on request, random stall bursts otherwise.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (out_gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", out_status, -1);
      end else begin
        want_res = pending_results.pop_front();
        if (out_status !== want_res.status)
          report_mismatch("status", out_status, want_res.status);
        if (out_position !== want_res.position)
          report_mismatch("position", out_position, want_res.position);
        if (out_entry_count !== want_res.entry_count)
          report_mismatch("entry_count", out_entry_count, want_res.entry_count);
        if (out_smallest !== want_res.smallest)
          report_mismatch("smallest", out_smallest, want_res.smallest);
      end
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_opcode   <= OP_INSERT;
    in_value    <= '0;
    in_gaps_on  = 1'b1;
    out_gaps_on = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mix(500);
    test_result_backpressure();
    in_gaps_on  = 1'b0;
    out_gaps_on = 1'b0;
    test_random_mix(250);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
